>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants for the command-driven I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // Default width of the phase tick counter.
  localparam int unsigned TickWidthDefault = 16;

  // Width of the stored half-period register.
  localparam int unsigned HalfPeriodWidth = 16;

  // Cycles per bus phase after reset.
  localparam int unsigned HalfPeriodReset = 250;

  // Word index of the half-period register on the configuration port.
  localparam logic RegHalfPeriod = 1'b0;

  // Command codes carried in the request.
  typedef enum logic [2:0] {
    KindStart  = 3'd0,
    KindStop   = 3'd1,
    KindTxByte = 3'd2,
    KindRxByte = 3'd3,
    KindTxAck  = 3'd4,
    KindRxAck  = 3'd5
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StPhase,
    StHold
  } state_e;

  // One bus phase as given out.
  typedef struct packed {
    logic       last;
    logic       ack;
    logic [7:0] rx;
    logic       sda;
    logic       scl;
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Turns bus commands into timed runs of SCL/SDA phases.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream is one command (start, stop, send
// byte, receive byte, send ACK/NACK, receive ACK). The engine answers on the
// master stream with one item per bus phase: the SCL and SDA levels to hold,
// the received byte or ACK bit on the final phase, and tlast on that phase.
// Start, stop and the ACK commands give 3 phases, receive byte 17 and send
// byte 25. Unused command codes are taken and dropped without output.
// Each phase is timed on a single shared phase counter from the half period
// (zero counts as one), after a setup step in StPhase, and the engine takes
// no new request until the last phase has run out.
// After a request, StPhase loads the first phase into the output register.
// A stalled receiver delays the next phase: a phase is only given out when
// the output register is free, and its hold time starts then.
// Reset returns both lines to the released idle level and the half period to
// 250. The half period is written through the APB port at address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_core #(
  parameter int unsigned TICK_WIDTH = i2cm_pkg::TickWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Command stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // [2:0] kind, [10:3] tx_byte, [11] ack_level, [19:12] line_samples
  input  wire logic [23:0] s_tdata_i,
  // Phase stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  // [0] scl_level, [1] sda_level, [9:2] rx_byte, [10] ack_seen
  output logic [15:0]      m_tdata_o,
  output logic             m_tlast_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned RegW =
      (TICK_WIDTH < i2cm_pkg::HalfPeriodWidth) ? TICK_WIDTH : i2cm_pkg::HalfPeriodWidth;

  i2cm_pkg::state_e state_d, state_q;
  i2cm_pkg::kind_e  kind_q;
  i2cm_pkg::phase_t phase;
  i2cm_pkg::phase_t out_q;

  logic [RegW-1:0] half_period_q;
  logic            out_valid_q;
  logic            scl_now_q, sda_now_q;
  logic [7:0]      shift_q, samp_q;
  logic            ack_q;
  logic [1:0]      sub_q;
  logic [3:0]      bit_q;

  logic            cmd_fire, cmd_valid, out_free;
  logic            load_en, advance_en, timer_done;
  logic [2:0]      kind_in;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = 32'(half_period_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= RegW'(i2cm_pkg::HalfPeriodReset);
    end else if (psel && penable && pwrite && (paddr[2] == i2cm_pkg::RegHalfPeriod)) begin
      half_period_q <= pwdata[RegW-1:0];
    end
  end

  // Request decode
  assign kind_in   = s_tdata_i[2:0];
  assign cmd_fire  = s_tvalid_i && s_tready_o;
  assign cmd_valid = (kind_in == i2cm_pkg::KindStart)  || (kind_in == i2cm_pkg::KindStop)  ||
                     (kind_in == i2cm_pkg::KindTxByte) || (kind_in == i2cm_pkg::KindRxByte) ||
                     (kind_in == i2cm_pkg::KindTxAck)  || (kind_in == i2cm_pkg::KindRxAck);
  assign out_free  = !out_valid_q || m_tready_i;

  // Current phase from the command and the bit and sub-phase counters.
  always_comb begin
    phase = '0;
    unique case (kind_q)
      i2cm_pkg::KindStart: begin
        phase.scl  = (sub_q != 2'd2);
        phase.sda  = (sub_q == 2'd0);
        phase.last = (sub_q == 2'd2);
      end
      i2cm_pkg::KindStop: begin
        phase.scl  = (sub_q == 2'd0) ? scl_now_q : 1'b1;
        phase.sda  = (sub_q == 2'd2);
        phase.last = (sub_q == 2'd2);
      end
      i2cm_pkg::KindTxByte: begin
        if (bit_q[3]) begin
          phase.sda  = sda_now_q;
          phase.last = 1'b1;
        end else begin
          phase.scl = (sub_q == 2'd2);
          phase.sda = (sub_q == 2'd0) ? sda_now_q : shift_q[7];
        end
      end
      i2cm_pkg::KindRxByte: begin
        phase.sda = 1'b1;
        if (bit_q[3]) begin
          phase.rx   = shift_q;
          phase.last = 1'b1;
        end else begin
          phase.scl = (sub_q == 2'd1);
        end
      end
      i2cm_pkg::KindTxAck: begin
        phase.scl  = (sub_q == 2'd1);
        phase.sda  = (sub_q == 2'd0) ? sda_now_q : ((sub_q == 2'd1) ? ack_q : 1'b1);
        phase.last = (sub_q == 2'd2);
      end
      i2cm_pkg::KindRxAck: begin
        phase.scl  = (sub_q == 2'd1);
        phase.sda  = 1'b1;
        phase.ack  = (sub_q == 2'd2) ? samp_q[0] : 1'b0;
        phase.last = (sub_q == 2'd2);
      end
      default: begin
        phase = '0;
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2cm_pkg::StIdle: begin
        if (cmd_fire && cmd_valid) state_d = i2cm_pkg::StPhase;
      end
      i2cm_pkg::StPhase: begin
        if (out_free) state_d = i2cm_pkg::StHold;
      end
      i2cm_pkg::StHold: begin
        if (timer_done) state_d = phase.last ? i2cm_pkg::StIdle : i2cm_pkg::StPhase;
      end
      default: begin
        state_d = i2cm_pkg::StIdle;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready_o = 1'b0;
    load_en    = 1'b0;
    advance_en = 1'b0;
    unique case (state_q)
      i2cm_pkg::StIdle:  s_tready_o = 1'b1;
      i2cm_pkg::StPhase: load_en    = out_free;
      i2cm_pkg::StHold:  advance_en = timer_done && !phase.last;
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2cm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared phase timer
  i2cm_tick_timer #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_en),
    .period_i(TICK_WIDTH'(half_period_q)),
    .done_o  (timer_done)
  );

  // Command registers and bit/sub-phase counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= i2cm_pkg::KindStart;
      shift_q <= '0;
      samp_q  <= '0;
      ack_q   <= 1'b0;
      sub_q   <= '0;
      bit_q   <= '0;
    end else if (cmd_fire && cmd_valid) begin
      kind_q <= i2cm_pkg::kind_e'(kind_in);
      samp_q <= s_tdata_i[19:12];
      ack_q  <= s_tdata_i[11];
      sub_q  <= '0;
      bit_q  <= '0;
      if (kind_in == i2cm_pkg::KindTxByte) begin
        shift_q <= s_tdata_i[10:3];
      end else if (kind_in == i2cm_pkg::KindRxByte) begin
        shift_q <= '0;
      end
    end else if (advance_en) begin
      if ((kind_q == i2cm_pkg::KindTxByte) && (sub_q == 2'd2)) begin
        // End of a sent bit: move on to the next one.
        sub_q   <= '0;
        bit_q   <= bit_q + 4'd1;
        shift_q <= {shift_q[6:0], 1'b0};
      end else if ((kind_q == i2cm_pkg::KindRxByte) && (sub_q == 2'd1)) begin
        // End of the SCL-high phase: take the sample into the byte.
        sub_q   <= '0;
        bit_q   <= bit_q + 4'd1;
        shift_q <= {shift_q[6:0], samp_q[7]};
        samp_q  <= {samp_q[6:0], 1'b0};
      end else begin
        sub_q <= sub_q + 2'd1;
      end
    end
  end

  // Bus level tracking and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_now_q   <= 1'b1;
      sda_now_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else if (load_en) begin
      scl_now_q   <= phase.scl;
      sda_now_q   <= phase.sda;
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      out_q <= phase;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_q.last;
  assign m_tdata_o  = {5'd0, out_q.ack, out_q.rx, out_q.sda, out_q.scl};

endmodule

`default_nettype wire

>>> rtl/i2cm_tick_timer.sv
// ----------------------------------------------------------------------------
// I2C master phase timer
// Counts the clock cycles of one bus phase and flags the end of the phase.
// A period of zero is treated as a period of one.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_tick_timer #(
  parameter int unsigned TICK_WIDTH = i2cm_pkg::TickWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [TICK_WIDTH-1:0] period_i,
  output logic                       done_o
);

  logic                  running_d, running_q;
  logic [TICK_WIDTH-1:0] count_d, count_q;

  // The phase ends once the count has reached the period.
  assign done_o = running_q && (count_q >= period_i);

  // Start loads a count of one; the count then advances until the phase ends.
  always_comb begin
    running_d = running_q;
    count_d   = count_q;
    if (start_i) begin
      running_d = 1'b1;
      count_d   = TICK_WIDTH'(1);
    end else if (done_o) begin
      running_d = 1'b0;
    end else if (running_q) begin
      count_d = count_q + TICK_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      count_q   <= '0;
    end else begin
      running_q <= running_d;
      count_q   <= count_d;
    end
  end

endmodule

`default_nettype wire
